// ----- sv/fppp_pkg.sv -----
package fppp_pkg;

  localparam int FracBits = 16;
  localparam int NumViewWords = 12;
  localparam int DivSteps = 48;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_FOCAL = 3'd2;
  localparam logic [2:0] CFG_WIDTH = 3'd3;
  localparam logic [2:0] CFG_HEIGHT = 3'd4;

  typedef struct packed {
    logic operation;
    logic [3:0] word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic in_front;
    logic on_screen;
  } out_word_t;

  // one division lane: two 48-bit numerator magnitudes, signs kept aside, over a 32-bit positive divisor
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic [47:0] rem_x;
    logic [47:0] quo_x;
    logic [47:0] rem_y;
    logic [47:0] quo_y;
    logic [31:0] dvs;
    logic front;
  } div_lane_t;

endpackage

// ----- sv/fppp_divider.sv -----
module fppp_divider (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  fppp_pkg::div_lane_t in_lane,
  output logic out_valid,
  output fppp_pkg::div_lane_t out_lane
);
  import fppp_pkg::*;

  // one quotient bit per stage for both numerators, restoring division
  localparam int Steps = DivSteps;

  div_lane_t lane [Steps];
  logic vld [Steps];

  function automatic logic [95:0] step(input logic [47:0] rem, input logic [47:0] quo,
                                       input logic [31:0] d);
    logic [48:0] t;
    logic [47:0] r;
    logic [47:0] q;
    begin
      t = {rem, quo[47]};
      q = {quo[46:0], 1'b0};
      if (t >= {17'd0, d}) begin
        t = t - {17'd0, d};
        q[0] = 1'b1;
      end
      r = t[47:0];
      step = {r, q};
    end
  endfunction

  genvar g;
  generate
    for (g = 0; g < Steps; g++) begin : g_stage
      div_lane_t src;
      logic src_v;
      div_lane_t nxt;
      logic [95:0] sx;
      logic [95:0] sy;
      if (g == 0) begin : g_head
        assign src = in_lane;
        assign src_v = in_valid;
      end else begin : g_tail
        assign src = lane[g-1];
        assign src_v = vld[g-1];
      end
      assign sx = step(src.rem_x, src.quo_x, src.dvs);
      assign sy = step(src.rem_y, src.quo_y, src.dvs);
      always_comb begin
        nxt = src;
        nxt.rem_x = sx[95:48];
        nxt.quo_x = sx[47:0];
        nxt.rem_y = sy[95:48];
        nxt.quo_y = sy[47:0];
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[g] <= 1'b0;
        end else if (adv) begin
          vld[g] <= src_v;
        end
        if (adv) begin
          lane[g] <= nxt;
        end
      end
    end
  endgenerate

  assign out_valid = vld[Steps-1];
  assign out_lane = lane[Steps-1];
endmodule

// ----- sv/fppp_view.sv -----
module fppp_view (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  fppp_pkg::in_word_t in_data,
  output logic out_valid,
  output fppp_pkg::div_lane_t out_lane
);
  import fppp_pkg::*;

  logic [31:0] view_words [NumViewWords];

  // stage 1: relative position and a copy of the basis
  logic v1;
  logic signed [31:0] rel [3];
  logic [31:0] basis [9];
  // stage 2: nine products
  logic v2;
  logic signed [63:0] prod [9];
  // stage 3: view coordinates
  logic v3;
  logic signed [31:0] vc [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumViewWords; i++) begin
        view_words[i] <= '0;
      end
    end else if (adv && in_valid && in_data.operation == OP_LOAD
                 && in_data.word_index < 4'(NumViewWords)) begin
      view_words[in_data.word_index] <= in_data.word_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && in_data.operation == OP_PROJECT;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      rel[0] <= in_data.point_x - view_words[9];
      rel[1] <= in_data.point_y - view_words[10];
      rel[2] <= in_data.point_z - view_words[11];
      // carry the basis with the word so later loads do not leak back
      for (int i = 0; i < 9; i++) begin
        basis[i] <= view_words[i];
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r*3+c] <= $signed(basis[r*3+c]) * rel[r];
        end
      end
      for (int c = 0; c < 3; c++) begin
        vc[c] <= 32'((prod[c] + prod[3+c] + prod[6+c]) >>> FracBits);
      end
    end
  end

  // hold the operand lane: magnitudes of (v << 16), sign kept aside
  logic front;
  logic [47:0] nx;
  logic [47:0] ny;
  assign front = !vc[2][31] && vc[2] != 32'sd0;
  assign nx = {vc[0], 16'd0};
  assign ny = {vc[1], 16'd0};

  always_comb begin
    out_lane = '0;
    out_lane.front = front;
    out_lane.neg_x = vc[0][31];
    out_lane.neg_y = vc[1][31];
    out_lane.quo_x = vc[0][31] ? -nx : nx;
    out_lane.quo_y = vc[1][31] ? -ny : ny;
    out_lane.dvs = front ? vc[2] : 32'd1;
  end
  assign out_valid = v3;
endmodule

// ----- sv/fixed_point_perspective_projector_core.sv -----
// Perspective projector: Q16.16 world points in, screen pixels out.
// Input channel in_valid/in_stall carries one in_word_t. A load word
// (operation 0) writes one of twelve view words (basis row-major, then camera
// x, y, z) and yields no output; a project word yields one out_word_t.
// Configuration: cfg_we, cfg_index, cfg_data write center, focal length and
// screen size, taken at once; write only while the block is idle.
// Throughput: one word per cycle unless out_stall holds the pipeline. A
// projection passes through 54 register stages: three transform stages, a
// 48-stage pipelined restoring divider (one quotient bit per stage for x
// and y together), two scaling stages, and the output register. Loads take
// effect for project words accepted after them.
// Reset clears the view words to zero, restores register defaults and
// empties the pipeline. When out_stall is high while a result waits, the
// whole pipeline holds and in_stall rises with it; nothing is dropped or
// repeated. The output register is refilled the same cycle it is taken, so
// the flow does not stall.
module fixed_point_perspective_projector_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  fppp_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output fppp_pkg::out_word_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import fppp_pkg::*;

  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [15:0] focal_length;
  logic [11:0] screen_width;
  logic [11:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= 16'sd160;
      center_y <= 16'sd120;
      focal_length <= 16'd256;
      screen_width <= 12'd320;
      screen_height <= 12'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        CFG_FOCAL: focal_length <= cfg_data;
        CFG_WIDTH: screen_width <= cfg_data[11:0];
        CFG_HEIGHT: screen_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic vv;
  div_lane_t vl;
  logic dv;
  div_lane_t dl;

  fppp_view u_view (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(in_valid), .in_data(in_data),
    .out_valid(vv), .out_lane(vl)
  );

  fppp_divider u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(vv), .in_lane(vl),
    .out_valid(dv), .out_lane(dl)
  );

  // scale stage 1: signed quotients times focal length
  logic s1v;
  logic s1f;
  logic [31:0] px;
  logic [31:0] py;
  logic [31:0] qx;
  logic [31:0] qy;
  assign qx = dl.neg_x ? -dl.quo_x[31:0] : dl.quo_x[31:0];
  assign qy = dl.neg_y ? -dl.quo_y[31:0] : dl.quo_y[31:0];

  // scale stage 2: centre offset
  logic s2v;
  logic s2f;
  logic signed [31:0] sx;
  logic signed [31:0] sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1v <= dv;
      s2v <= s1v;
      out_valid <= s2v;
    end
    if (adv) begin
      s1f <= dl.front;
      px <= 32'(qx * {16'd0, focal_length});
      py <= 32'(qy * {16'd0, focal_length});
      s2f <= s1f;
      sx <= {{16{center_x[15]}}, center_x} + 32'($signed(px) >>> FracBits);
      sy <= {{16{center_y[15]}}, center_y} - 32'($signed(py) >>> FracBits);
      out_data.in_front <= s2f;
      out_data.screen_x <= s2f ? sx : 32'sd0;
      out_data.screen_y <= s2f ? sy : 32'sd0;
      out_data.on_screen <= s2f && !sx[31] && !sy[31]
                            && sx < {20'd0, screen_width}
                            && sy < {20'd0, screen_height};
    end
  end
endmodule

// ----- sim/fppp_checker.sv -----
`timescale 1ns / 1ps

module fppp_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  fppp_pkg::in_word_t in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  fppp_pkg::out_word_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int errors,
  output int pending,
  output int projections,
  output int visible
);
  import fppp_pkg::*;

  logic [31:0] view [NumViewWords];
  logic signed [31:0] cx, cy;
  logic [15:0] focal;
  logic [11:0] sw, sh;
  out_word_t pixel_q [$];

  function automatic logic [31:0] scaled_ratio(input logic signed [31:0] v,
                                               input logic signed [31:0] vz);
    longint num, q;
    logic [31:0] p;
    num = longint'(v) * 64'sd65536;
    q = num / longint'(vz);
    p = q[31:0] * {16'b0, focal};
    return {{16{p[31]}}, p[31:16]};
  endfunction

  function automatic out_word_t predict_pixel(input in_word_t w);
    logic signed [31:0] rel [3];
    logic signed [31:0] vc [3];
    logic signed [63:0] acc;
    logic signed [31:0] sx, sy;
    out_word_t r;
    int c, k;
    rel[0] = w.point_x - view[9];
    rel[1] = w.point_y - view[10];
    rel[2] = w.point_z - view[11];
    for (c = 0; c < 3; c++) begin
      acc = '0;
      for (k = 0; k < 3; k++)
        acc += longint'($signed(view[k * 3 + c])) * longint'(rel[k]);
      vc[c] = acc[47:16];
    end
    r = '0;
    if (vc[2] > 0) begin
      sx = cx + scaled_ratio(vc[0], vc[2]);
      sy = cy - scaled_ratio(vc[1], vc[2]);
      r.screen_x = sx;
      r.screen_y = sy;
      r.in_front = 1'b1;
      r.on_screen = !sx[31] && ($unsigned(sx) < {20'b0, sw}) &&
                    !sy[31] && ($unsigned(sy) < {20'b0, sh});
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      for (int i = 0; i < NumViewWords; i++) view[i] = '0;
      cx = 32'sd160;
      cy = 32'sd120;
      focal = 16'd256;
      sw = 12'd320;
      sh = 12'd240;
      pixel_q.delete();
      errors = 0;
      projections = 0;
      visible = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X: cx = {{16{cfg_data[15]}}, cfg_data};
          CFG_CENTER_Y: cy = {{16{cfg_data[15]}}, cfg_data};
          CFG_FOCAL:    focal = cfg_data;
          CFG_WIDTH:    sw = cfg_data[11:0];
          CFG_HEIGHT:   sh = cfg_data[11:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output word %h", out_data);
        end else begin
          want = pixel_q.pop_front();
          if (want.screen_x !== out_data.screen_x || want.screen_y !== out_data.screen_y ||
              want.in_front !== out_data.in_front ||
              want.on_screen !== out_data.on_screen) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected x=%0d y=%0d front=%b on=%b,",
                       want.screen_x, want.screen_y, want.in_front, want.on_screen,
                       " got x=%0d y=%0d front=%b on=%b",
                       out_data.screen_x, out_data.screen_y, out_data.in_front,
                       out_data.on_screen);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_LOAD) begin
          if (in_data.word_index < NumViewWords) view[in_data.word_index] = in_data.word_value;
        end else begin
          want = predict_pixel(in_data);
          pixel_q.push_back(want);
          projections++;
          if (want.on_screen) visible++;
        end
      end
    end
    pending = pixel_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import fppp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int errors, pending, projections, visible;
  int send_idle = 0, recv_idle = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  int cycles = 0;
  logic [31:0] cam [3];

  always #5 clk = ~clk;

  fixed_point_perspective_projector_core uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fppp_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .projections(projections), .visible(visible)
  );

  // receiver: random stall plus a single long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1) || ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(input in_word_t w);
    // idle while a fresh draw falls under send_idle, so the sender idles in about send_idle of a hundred
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_word_t load_word(input int idx, input logic [31:0] v);
    in_word_t w;
    w = in_word_t'($bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    w.operation = OP_LOAD;
    w.word_index = idx[3:0];
    w.word_value = v;
    return w;
  endfunction

  function automatic in_word_t point_word(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
    in_word_t w;
    w = in_word_t'($bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    w.operation = OP_PROJECT;
    w.point_x = x;
    w.point_y = y;
    w.point_z = z;
    return w;
  endfunction

  function automatic logic [31:0] near(input int span);
    logic [31:0] r;
    r = $urandom & ((32'd1 << span) - 1);
    return $urandom_range(1) ? r : -r;
  endfunction

  task automatic load_random_view();
    logic [31:0] v;
    for (int i = 0; i < 12; i++) begin
      case ($urandom_range(3))
        0: v = $urandom_range(2) == 0 ? 32'h0 : ($urandom_range(1) ? 32'h10000 : 32'hffff0000);
        1, 2: v = near(18);
        default: v = $urandom;
      endcase
      if (i >= 9) begin
        v = $urandom_range(4) == 0 ? $urandom : near(22);
        cam[i - 9] = v;
      end
      send(load_word(i, v));
    end
  endtask

  task automatic run_phase(input int ph);
    int span;
    logic [31:0] x, y, z;
    drain();
    repeat (60) @(posedge clk);
    case (ph)
      0: begin
        write_cfg(CFG_CENTER_X, 16'd160); write_cfg(CFG_CENTER_Y, 16'd120);
        write_cfg(CFG_FOCAL, 16'd256); write_cfg(CFG_WIDTH, 16'd320);
        write_cfg(CFG_HEIGHT, 16'd240);
      end
      1: begin
        write_cfg(CFG_CENTER_X, 16'h8000); write_cfg(CFG_CENTER_Y, 16'h7fff);
        write_cfg(CFG_FOCAL, 16'hffff); write_cfg(CFG_WIDTH, 16'd4095);
        write_cfg(CFG_HEIGHT, 16'd1);
      end
      2: begin
        write_cfg(CFG_CENTER_X, 16'h7fff); write_cfg(CFG_CENTER_Y, 16'h8000);
        write_cfg(CFG_FOCAL, 16'd0); write_cfg(CFG_WIDTH, 16'd1);
        write_cfg(CFG_HEIGHT, 16'd4095);
      end
      default: begin
        write_cfg(CFG_CENTER_X, 16'($urandom_range(0, 1000)));
        write_cfg(CFG_CENTER_Y, 16'($urandom_range(0, 1000)));
        write_cfg(CFG_FOCAL, 16'($urandom_range(0, 65535)));
        write_cfg(CFG_WIDTH, 16'($urandom_range(1, 4095)));
        write_cfg(CFG_HEIGHT, 16'($urandom_range(1, 4095)));
        write_cfg(3'd5 + 3'($urandom_range(2)), 16'($urandom));
      end
    endcase
    send_idle = (ph < 2) ? 36 : (ph < 4) ? 50 : 0;
    recv_idle = (ph < 2) ? 50 : (ph < 4) ? 36 : 0;
    load_random_view();
    for (int n = 0; n < 270; n++) begin
      if (n == 100 && ph == 0) hold_req++;
      if (n == 150 && ph == 1) drain();
      case ($urandom_range(49))
        0: send(load_word($urandom_range(12, 15), $urandom));
        1, 2, 3, 4: send(load_word($urandom_range(0, 11),
                                    $urandom_range(1) ? near(18) : $urandom));
        5, 6: send(point_word($urandom, $urandom, $urandom));
        default: begin
          span = $urandom_range(6, 24);
          x = cam[0] + near(span);
          y = cam[1] + near(span);
          z = cam[2] + near(span);
          send(point_word(x, y, z));
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // identity basis, camera at origin
    send(load_word(0, 32'h10000));
    send(load_word(4, 32'h10000));
    send(load_word(8, 32'h10000));
    send(point_word(0, 0, 32'h10000));
    send(point_word(32'h10000, 32'hffff0000, 32'h20000));
    send(point_word(0, 0, 0));
    send(point_word(0, 0, 32'hffff0000));
    send(point_word(32'h7fffffff, 32'h80000000, 32'h1));
    send(point_word(32'h80000000, 32'h7fffffff, 32'h7fffffff));
    send(point_word(32'hffffffff, 32'hffffffff, 32'h7fffffff));
    send(load_word(15, 32'hffffffff));
    send(load_word(12, 32'h80000000));
    send(point_word(32'h5000, 32'h5000, 32'h10000));
    send(load_word(11, 32'h80000000));
    send(point_word(0, 0, 0));
    send(load_word(11, 32'h7fffffff));
    send(point_word(0, 0, 0));
    send(load_word(2, 32'hffffffff));
    send(load_word(1, 32'h7fffffff));
    send(point_word(32'h12345678, 32'h9abcdef0, 32'h0fedcba9));
    send(load_word(9, 32'h80000000));
    send(load_word(10, 32'h7fffffff));
    send(point_word(0, 32'h80000000, 32'hffffffff));
    for (int ph = 0; ph < 6; ph++) run_phase(ph);
    drain();
    repeat (80) @(posedge clk);
    $display("covered %0d projections (%0d on screen), view loads, six register settings,",
             projections, visible);
    $display("random stalls on both sides, a long output hold and a full drain");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- fixed_point_perspective_projector_core.f -----
sv/fppp_pkg.sv
sv/fppp_divider.sv
sv/fppp_view.sv
sv/fixed_point_perspective_projector_core.sv
sim/fppp_checker.sv
sim/testbench.sv
